// ----- sv/palette_index_bit_packer_unit_defines.svh -----
// Assertion macros used by the checker of the packer.
`ifndef PALETTE_INDEX_BIT_PACKER_UNIT_DEFINES_SVH
`define PALETTE_INDEX_BIT_PACKER_UNIT_DEFINES_SVH

// Immediate implication checked at every edge outside reset.
`define PIBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PIBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pibp_pkg.sv -----
`timescale 1ns / 1ps
package pibp_pkg;

  localparam int unsigned ENTRIES        = 4096;
  localparam int unsigned PAL_DEPTH      = 256;
  localparam int unsigned ID_BITS        = 16;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned MIN_BITS_RESET = 4;
  localparam int unsigned QDEPTH         = 4;

  localparam int unsigned ENT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned EADDR_W = $clog2(ENTRIES);
  localparam int unsigned PAL_W   = $clog2(PAL_DEPTH + 1);
  localparam int unsigned PADDR_W = $clog2(PAL_DEPTH);
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned BPE_W   = 4;
  localparam int unsigned POS_W   = $clog2(WORD_BITS + 1);
  localparam int unsigned QADDR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Indices per word for each bits-per-entry value.
  localparam logic [POS_W-1:0] PER_WORD [16] = '{
    POS_W'(0),       POS_W'(64 / 1),  POS_W'(64 / 2),  POS_W'(64 / 3),
    POS_W'(64 / 4),  POS_W'(64 / 5),  POS_W'(64 / 6),  POS_W'(64 / 7),
    POS_W'(64 / 8),  POS_W'(64 / 9),  POS_W'(64 / 10), POS_W'(64 / 11),
    POS_W'(64 / 12), POS_W'(64 / 13), POS_W'(64 / 14), POS_W'(64 / 15)
  };

  // Packed words per section for each bits-per-entry value.
  localparam logic [ENT_W-1:0] WORD_TOTAL [16] = '{
    ENT_W'(0),
    ENT_W'((ENTRIES + 64 / 1 - 1) / (64 / 1)),
    ENT_W'((ENTRIES + 64 / 2 - 1) / (64 / 2)),
    ENT_W'((ENTRIES + 64 / 3 - 1) / (64 / 3)),
    ENT_W'((ENTRIES + 64 / 4 - 1) / (64 / 4)),
    ENT_W'((ENTRIES + 64 / 5 - 1) / (64 / 5)),
    ENT_W'((ENTRIES + 64 / 6 - 1) / (64 / 6)),
    ENT_W'((ENTRIES + 64 / 7 - 1) / (64 / 7)),
    ENT_W'((ENTRIES + 64 / 8 - 1) / (64 / 8)),
    ENT_W'((ENTRIES + 64 / 9 - 1) / (64 / 9)),
    ENT_W'((ENTRIES + 64 / 10 - 1) / (64 / 10)),
    ENT_W'((ENTRIES + 64 / 11 - 1) / (64 / 11)),
    ENT_W'((ENTRIES + 64 / 12 - 1) / (64 / 12)),
    ENT_W'((ENTRIES + 64 / 13 - 1) / (64 / 13)),
    ENT_W'((ENTRIES + 64 / 14 - 1) / (64 / 14)),
    ENT_W'((ENTRIES + 64 / 15 - 1) / (64 / 15))
  };

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_BPE    = 3'd0,
    KIND_COUNT  = 3'd1,
    KIND_ID     = 3'd2,
    KIND_WCOUNT = 3'd3,
    KIND_WORD   = 3'd4,
    KIND_NOTRDY = 3'd5
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [ID_BITS-1:0] id;
  } q_item_t;

  // Greater of the effective minimum and ceil(log2(count)).
  function automatic logic [BPE_W-1:0] bits_per_entry(logic [BPE_W-1:0] mn,
                                                       logic [PAL_W-1:0] cnt);
    logic [BPE_W-1:0] need;
    logic [BPE_W-1:0] lo;
    need = '0;
    lo   = (mn == '0) ? BPE_W'(1) : mn;
    for (int n = 0; n < PAL_W; n++) begin
      if (((PAL_W + 1)'(1) << n) < {1'b0, cnt}) need = need + BPE_W'(1);
    end
    return (need > lo) ? need : lo;
  endfunction

endpackage

// ----- sv/pibp_fifo.sv -----
`timescale 1ns / 1ps
module pibp_fifo
  import pibp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [ID_BITS-1:0] block_id,
  output logic               q_valid,
  output q_item_t            q_item,
  input  logic               q_pop
);

  q_item_t             mem [QDEPTH];
  logic [QADDR_W-1:0]  wr_ptr;
  logic [QADDR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;
  q_item_t             item_in;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_comb begin
    item_in.op = func ? OP_FETCH : OP_LOAD;
    item_in.id = block_id;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QADDR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QADDR_W'(1);
      priority if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
      else count <= count;
    end
  end

endmodule

// ----- sv/pibp_engine.sv -----
`timescale 1ns / 1ps
module pibp_engine
  import pibp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [BPE_W-1:0]     cfg_data,
  input  logic                 q_valid,
  input  q_item_t              q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [WORD_BITS-1:0] value,
  output logic                 last_word,
  output logic                 overflow
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_WR       = 8'b0000_1000,
    S_ID_OUT   = 8'b0001_0000,
    S_PK_RD    = 8'b0010_0000,
    S_PK_ACC   = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  typedef enum logic [5:0] {
    PH_LOAD   = 6'b00_0001,
    PH_BPE    = 6'b00_0010,
    PH_COUNT  = 6'b00_0100,
    PH_IDS    = 6'b00_1000,
    PH_WCOUNT = 6'b01_0000,
    PH_WORDS  = 6'b10_0000
  } phase_t;

  state_t               state;
  phase_t               phase;
  logic [PAL_W-1:0]     cnt;
  logic [ENT_W-1:0]     load_cnt;
  logic [PAL_W-1:0]     ptr;
  logic [ENT_W-1:0]     ent;
  logic [ENT_W-1:0]     wptr;
  logic                 ovf;
  logic [BPE_W-1:0]     min_bits;
  logic [ID_BITS-1:0]   cur_id;
  logic [IDX_W-1:0]     found;
  logic [WORD_BITS-1:0] acc;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     icnt;
  kind_t                pend_kind;
  logic [WORD_BITS-1:0] pend_value;
  logic                 pend_last;
  logic                 pend_ovf;

  logic [ID_BITS-1:0]   pal_mem [PAL_DEPTH];
  logic [ID_BITS-1:0]   pal_rdata;
  logic [IDX_W-1:0]     idx_mem [ENTRIES];
  logic [IDX_W-1:0]     idx_rdata;

  logic [BPE_W-1:0]     bpe;
  logic [POS_W-1:0]     per_word;
  logic [ENT_W-1:0]     wtot;
  logic                 pal_we;

  assign bpe      = bits_per_entry(min_bits, cnt);
  assign per_word = PER_WORD[bpe];
  assign wtot     = WORD_TOTAL[bpe];
  assign q_pop    = (state == S_IDLE);
  assign pal_we   = (state == S_SRCH_RD) && (ptr == cnt) && (cnt < PAL_W'(PAL_DEPTH));

  // The palette is always read at the search/emit pointer.
  always_ff @(posedge clk) begin
    pal_rdata <= pal_mem[ptr[PADDR_W-1:0]];
    if (pal_we) pal_mem[cnt[PADDR_W-1:0]] <= cur_id;
  end

  always_ff @(posedge clk) begin
    idx_rdata <= idx_mem[ent[EADDR_W-1:0]];
    if (state == S_WR) idx_mem[load_cnt[EADDR_W-1:0]] <= found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LOAD;
      cnt       <= '0;
      load_cnt  <= '0;
      ptr       <= '0;
      ovf       <= 1'b0;
      min_bits  <= BPE_W'(MIN_BITS_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) min_bits <= cfg_data;
      if (state == S_EMIT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_LOAD) begin
              // Loads after the section is full are dropped.
              if (phase == PH_LOAD) begin
                cur_id <= q_item.id;
                ptr    <= '0;
                state  <= S_SRCH_RD;
              end
            end else begin
              pend_ovf  <= ovf;
              pend_last <= 1'b0;
              unique case (phase)
                PH_LOAD: begin
                  pend_kind  <= KIND_NOTRDY;
                  pend_value <= '0;
                  state      <= S_EMIT;
                end
                PH_BPE: begin
                  pend_kind  <= KIND_BPE;
                  pend_value <= WORD_BITS'(bpe);
                  phase      <= PH_COUNT;
                  state      <= S_EMIT;
                end
                PH_COUNT: begin
                  pend_kind  <= KIND_COUNT;
                  pend_value <= WORD_BITS'(cnt);
                  ptr        <= '0;
                  phase      <= (cnt != '0) ? PH_IDS : PH_WCOUNT;
                  state      <= S_EMIT;
                end
                PH_IDS: begin
                  state <= S_ID_OUT;
                end
                PH_WCOUNT: begin
                  pend_kind  <= KIND_WCOUNT;
                  pend_value <= WORD_BITS'(wtot);
                  wptr       <= '0;
                  ent        <= '0;
                  phase      <= PH_WORDS;
                  state      <= S_EMIT;
                end
                PH_WORDS: begin
                  acc   <= '0;
                  pos   <= '0;
                  icnt  <= '0;
                  state <= S_PK_RD;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end

        S_SRCH_RD: begin
          if (ptr == cnt) begin
            // No match: append, or flag overflow when the palette is full.
            if (cnt < PAL_W'(PAL_DEPTH)) begin
              found <= cnt[IDX_W-1:0];
              cnt   <= cnt + PAL_W'(1);
            end else begin
              ovf   <= 1'b1;
              found <= '0;
            end
            state <= S_WR;
          end else begin
            state <= S_SRCH_CMP;
          end
        end

        S_SRCH_CMP: begin
          if (pal_rdata == cur_id) begin
            found <= ptr[IDX_W-1:0];
            state <= S_WR;
          end else begin
            ptr   <= ptr + PAL_W'(1);
            state <= S_SRCH_RD;
          end
        end

        S_WR: begin
          load_cnt <= load_cnt + ENT_W'(1);
          if (load_cnt + ENT_W'(1) == ENT_W'(ENTRIES)) phase <= PH_BPE;
          state <= S_IDLE;
        end

        S_ID_OUT: begin
          pend_kind  <= KIND_ID;
          pend_value <= WORD_BITS'(pal_rdata);
          if (ptr + PAL_W'(1) >= cnt) begin
            ptr   <= '0;
            phase <= PH_WCOUNT;
          end else begin
            ptr <= ptr + PAL_W'(1);
          end
          state <= S_EMIT;
        end

        S_PK_RD: begin
          if (icnt == per_word || ent == ENT_W'(ENTRIES)) begin
            pend_kind  <= KIND_WORD;
            pend_value <= acc;
            pend_ovf   <= ovf;
            wptr       <= wptr + ENT_W'(1);
            if (wptr + ENT_W'(1) == wtot) begin
              // Final word closes the section.
              pend_last <= 1'b1;
              cnt       <= '0;
              load_cnt  <= '0;
              ptr       <= '0;
              ovf       <= 1'b0;
              phase     <= PH_LOAD;
            end else begin
              pend_last <= 1'b0;
            end
            state <= S_EMIT;
          end else begin
            state <= S_PK_ACC;
          end
        end

        S_PK_ACC: begin
          acc   <= acc | (WORD_BITS'(idx_rdata) << pos);
          pos   <= pos + POS_W'(bpe);
          icnt  <= icnt + POS_W'(1);
          ent   <= ent + ENT_W'(1);
          state <= S_PK_RD;
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            kind      <= pend_kind;
            value     <= pend_value;
            last_word <= pend_last;
            overflow  <= pend_ovf;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/palette_index_bit_packer_unit.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_stall  func, block_id
// out      out_valid/ out_stall kind, value, last_word, overflow
// cfg      cfg_valid/ cfg_ready cfg_data (min_bits_per_entry)
// A load compares its id against the palette entries one at a time, reading
// them through the single palette read port. A packed word gathers its
// indices one at a time through the single index-store read port; every
// fetch also waits while the output is stalled.
// Reset clears control state only; the memories are read only where written.
// A four-deep queue keeps accepting transactions, until it is full, while the
// back end or the output register is stalled.
module palette_index_bit_packer_unit
  import pibp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [ID_BITS-1:0]   block_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [WORD_BITS-1:0] value,
  output logic                 last_word,
  output logic                 overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [BPE_W-1:0]     cfg_data
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  pibp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .block_id (block_id),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pibp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .last_word (last_word),
    .overflow  (overflow)
  );

endmodule

// ----- sv/pibp_checker.sv -----
`timescale 1ns / 1ps
`include "palette_index_bit_packer_unit_defines.svh"
module pibp_checker
  import pibp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 func,
  input logic [ID_BITS-1:0]   block_id,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [2:0]           kind,
  input logic [WORD_BITS-1:0] value,
  input logic                 last_word,
  input logic                 overflow
);

  `PIBP_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(func) && $stable(block_id), "stalled transaction changed")
  `PIBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(value) && $stable(kind), "stalled result changed")
  `PIBP_ASSERT_NOW(a_kind_range, out_valid, kind <= KIND_NOTRDY, "result kind out of range")
  `PIBP_ASSERT_NOW(a_last_word, out_valid && last_word, kind == KIND_WORD,
    "last flag on a non-word result")
  `PIBP_ASSERT_NOW(a_bpe_range, out_valid && kind == KIND_BPE,
    value[63:4] == '0 && value[3:0] != '0, "bits per entry out of range")

endmodule

bind palette_index_bit_packer_unit pibp_checker u_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import pibp_pkg::*;

  typedef enum int {
    SEC_LOAD, SEC_BPE, SEC_COUNT, SEC_IDS, SEC_WCOUNT, SEC_WORDS
  } sec_phase_t;

  typedef struct {
    kind_t       kind;
    logic [63:0] value;
    logic        last;
    logic        ovf;
  } section_item_t;

  typedef struct {
    op_t         op;
    logic [15:0] id;
    bit          typed;
    kind_t       kind;
    logic [63:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = OP_LOAD;
  logic [15:0] block_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [63:0] value;
  logic        last_word;
  logic        overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // Typed expectation that travels with the transaction being driven.
  bit          drv_typed = 1'b0;
  kind_t       drv_kind = KIND_NOTRDY;
  logic [63:0] drv_value = '0;

  palette_index_bit_packer_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .block_id(block_id),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .value(value),
    .last_word(last_word), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Packer state as predicted.
  logic [7:0]  pk_index [ENTRIES];
  logic [15:0] pk_palette [PAL_DEPTH];
  int          pk_count, pk_loaded, pk_ptr;
  sec_phase_t  pk_phase;
  bit          pk_ovf;
  logic [3:0]  pk_min;

  section_item_t expected_items[$];
  int          fails = 0;
  longint      cycle = 0;
  int          stall_mode = 0;
  int          burst_left = 0;

  function automatic int pk_bits();
    int mn;
    int need;
    mn = (pk_min == 0) ? 1 : pk_min;
    need = 0;
    while (need < 16 && (1 << need) < pk_count) need++;
    return (need > mn) ? need : mn;
  endfunction

  function automatic int pk_words();
    int pw;
    pw = 64 / pk_bits();
    return (ENTRIES + pw - 1) / pw;
  endfunction

  function automatic logic [63:0] pk_pack(int w);
    int b;
    int pw;
    logic [63:0] acc;
    b = pk_bits();
    pw = 64 / b;
    acc = '0;
    for (int i = 0; i < pw; i++) begin
      if (w * pw + i >= ENTRIES) break;
      acc |= 64'(pk_index[w * pw + i]) << (i * b);
    end
    return acc;
  endfunction

  function automatic void pk_new_section();
    pk_count = 0;
    pk_loaded = 0;
    pk_phase = SEC_LOAD;
    pk_ptr = 0;
    pk_ovf = 1'b0;
  endfunction

  // Advances the predicted state by one transaction; returns 1 with a result.
  function automatic bit pk_step(logic op, logic [15:0] id, output section_item_t r);
    int found;
    bit hit;
    r.kind = KIND_NOTRDY;
    r.value = '0;
    r.last = 1'b0;
    if (op == OP_LOAD) begin
      if (pk_phase != SEC_LOAD || pk_loaded >= ENTRIES) return 0;
      hit = 0;
      found = 0;
      for (int i = 0; i < pk_count; i++) begin
        if (pk_palette[i] == id) begin
          hit = 1;
          found = i;
          break;
        end
      end
      if (!hit) begin
        if (pk_count < PAL_DEPTH) begin
          found = pk_count;
          pk_palette[pk_count] = id;
          pk_count++;
        end else begin
          pk_ovf = 1'b1;
        end
      end
      pk_index[pk_loaded] = 8'(found);
      pk_loaded++;
      if (pk_loaded >= ENTRIES) begin
        pk_phase = SEC_BPE;
        pk_ptr = 0;
      end
      return 0;
    end
    r.ovf = pk_ovf;
    case (pk_phase)
      SEC_BPE: begin
        r.kind = KIND_BPE;
        r.value = 64'(pk_bits());
        pk_phase = SEC_COUNT;
      end
      SEC_COUNT: begin
        r.kind = KIND_COUNT;
        r.value = 64'(pk_count);
        pk_ptr = 0;
        pk_phase = (pk_count > 0) ? SEC_IDS : SEC_WCOUNT;
      end
      SEC_IDS: begin
        r.kind = KIND_ID;
        r.value = 64'(pk_palette[pk_ptr]);
        pk_ptr++;
        if (pk_ptr >= pk_count) begin
          pk_ptr = 0;
          pk_phase = SEC_WCOUNT;
        end
      end
      SEC_WCOUNT: begin
        r.kind = KIND_WCOUNT;
        r.value = 64'(pk_words());
        pk_ptr = 0;
        pk_phase = SEC_WORDS;
      end
      SEC_WORDS: begin
        r.kind = KIND_WORD;
        r.value = pk_pack(pk_ptr);
        pk_ptr++;
        if (pk_ptr >= pk_words()) begin
          r.last = 1'b1;
          pk_new_section();
        end
      end
      default: ;
    endcase
    return 1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    fails++;
  endtask

  initial begin
    pk_min = 4'(MIN_BITS_RESET);
    pk_new_section();
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 64'd20000000) begin
      $display("FAIL palette_index_bit_packer_unit");
      $finish;
    end
  end

  // Receiver stall pattern: free running, random, or periodic bursts.
  always @(posedge clk) begin
    if (cycle % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= (cycle % 16) < 6;
    endcase
  end

  always @(posedge clk) begin
    section_item_t r;
    section_item_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (pk_step(func, block_id, r)) begin
          if (drv_typed) begin
            r.kind = drv_kind;
            r.value = drv_value;
            r.last = 1'b0;
            r.ovf = 1'b0;
          end
          expected_items.insert(expected_items.size(), r);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          report("unexpected transaction kind", 64'(kind), 64'(0));
        end else begin
          e = expected_items.pop_front();
          if (kind !== e.kind) report("kind", 64'(kind), 64'(e.kind));
          if (value !== e.value) report("value", value, e.value);
          if (last_word !== e.last) report("last_word", 64'(last_word), 64'(e.last));
          if (overflow !== e.ovf) report("overflow", 64'(overflow), 64'(e.ovf));
        end
      end
    end
  end

  // Drives one transaction, waits for the edge that accepts it, and at times idles the input before returning.
  task automatic send(op_t op, logic [15:0] id, bit typed = 0,
                      kind_t k = KIND_NOTRDY, logic [63:0] v = '0);
    in_valid <= 1'b1;
    func <= op;
    block_id <= id;
    drv_typed <= typed;
    drv_kind <= k;
    drv_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_items.size() != 0) @(posedge clk);
    // A load can still be searching a full palette after the last result.
    repeat (600) @(posedge clk);
  endtask

  task automatic write_min(logic [3:0] mn);
    cfg_valid <= 1'b1;
    cfg_data <= mn;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    pk_min = mn;
    @(posedge clk);
  endtask

  // Loads the rest of a section from a pool of distinct ids, then drains it.
  task automatic run_section(int pool_size);
    logic [15:0] pool[$];
    bit          seen[int];
    logic [15:0] cand;
    int          intro, remaining, sel, nfetch;
    while (pool.size() < pool_size) begin
      cand = 16'($urandom);
      if (!seen.exists(cand)) begin
        seen[cand] = 1;
        pool.insert(pool.size(), cand);
      end
    end
    intro = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    remaining = ENTRIES - pk_loaded;
    while (remaining > 0) begin
      if ($urandom_range(0, 31) == 0) begin
        send(OP_FETCH, 16'($urandom));
      end else begin
        if (intro < pool_size &&
            (intro == 0 || $urandom_range(0, 15) == 0 || remaining <= pool_size - intro)) begin
          sel = intro;
          intro++;
        end else begin
          sel = $urandom_range(0, intro - 1);
          if ($urandom_range(0, 7) != 0) sel = sel % 8;
        end
        send(OP_LOAD, pool[sel]);
        remaining--;
      end
    end
    // Loads once loading is done are ignored.
    send(OP_LOAD, 16'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);
    nfetch = 3 + pk_count + pk_words();
    repeat (nfetch) send(OP_FETCH, 16'($urandom));
    send(OP_FETCH, '0);
  endtask

  stim_row_t opening[] = '{
    '{OP_FETCH, 16'h0000, 1, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h0000, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'hFFFF, 0, KIND_NOTRDY, 64'd0},
    '{OP_FETCH, 16'hFFFF, 1, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h0000, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'hAAAA, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h5555, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'hFFFF, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h8000, 0, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h0001, 0, KIND_NOTRDY, 64'd0},
    '{OP_FETCH, 16'h1234, 1, KIND_NOTRDY, 64'd0},
    '{OP_LOAD,  16'h8000, 0, KIND_NOTRDY, 64'd0}
  };

  // A section needs a full load, so only two are run: an overflowing palette
  // at the reset minimum, then a small palette under a minimum above 8.
  int         pools[2] = '{276, 3};
  logic [3:0] mins[2] = '{4'd4, 4'd9};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening[i])
      send(opening[i].op, opening[i].id, opening[i].typed, opening[i].kind, opening[i].value);
    drv_typed <= 1'b0;
    for (int s = 0; s < 2; s++) begin
      if (s > 0) begin
        settle();
        write_min(mins[s]);
      end
      run_section(pools[s]);
    end
    in_valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fails == 0)
      $display("PASS palette_index_bit_packer_unit");
    else
      $display("FAIL palette_index_bit_packer_unit");
    $finish;
  end

endmodule
